>>> sv/rasq_pkg.sv
package rasq_pkg;

    // phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_RAMP   = 3'd1;
    localparam logic [2:0] PH_SETTLE = 3'd2;
    localparam logic [2:0] PH_LOCKED = 3'd3;
    localparam logic [2:0] PH_FAULT  = 3'd4;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_ABORT = 2'd2;

    // fault reasons
    localparam logic FAULT_NONE    = 1'b0;
    localparam logic FAULT_TIMEOUT = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_RAMP_LEN    = 3'd0;
    localparam logic [2:0] CFG_ALIGN_VOLT  = 3'd1;
    localparam logic [2:0] CFG_SETTLE_TMO  = 3'd2;
    localparam logic [2:0] CFG_MAX_SPEED   = 3'd3;
    localparam logic [2:0] CFG_SAMPLES     = 3'd4;
    localparam logic [2:0] CFG_POLE_PAIRS  = 3'd5;
    localparam logic [2:0] CFG_REVERSE     = 3'd6;

    // configuration reset values
    localparam logic [23:0] RST_RAMP_LEN   = 24'd500000;
    localparam logic [15:0] RST_ALIGN_VOLT = 16'd2000;
    localparam logic [23:0] RST_SETTLE_TMO = 24'd2000000;
    localparam logic [15:0] RST_MAX_SPEED  = 16'd100;
    localparam logic [7:0]  RST_SAMPLES    = 8'd20;
    localparam logic [5:0]  RST_POLE_PAIRS = 6'd7;
    localparam logic        RST_REVERSE    = 1'b0;

    // shared multiplier operand selects
    localparam logic [1:0] MUL_RAMP = 2'd0;  // align * elapsed
    localparam logic [1:0] MUL_MAG  = 2'd1;  // |delta| * 1e6
    localparam logic [1:0] MUL_SPD  = 2'd2;  // max speed * dt
    localparam logic [1:0] MUL_OFS  = 2'd3;  // angle * pole pairs

    localparam int MUL_W = 24;
    localparam logic [MUL_W-1:0] MAG_SCALE = 24'd1000000;

    localparam logic [19:0] OFFSET_MAX = 20'd524287;
    localparam logic [7:0]  COUNT_MAX  = 8'hFF;
    localparam logic [31:0] ELAPSED_MAX = 32'hFFFF_FFFF;

    // ramp divider: 40-bit dividend, 24-bit divisor, quotient below 2^16
    localparam int DIV_N_BITS = 40;
    localparam int DIV_D_BITS = 24;
    localparam int DIV_Q_BITS = 16;

    // controller to datapath
    typedef struct packed {
        logic       load;       // capture input item
        logic       prep;       // elapsed sum and angle delta
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       div_start;
        logic       commit;     // update state, write output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic tick_ramp;
        logic tick_settle;
        logic ramp_done;
        logic timeout;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

>>> sv/rasq_div.sv
module rasq_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [rasq_pkg::DIV_N_BITS-1:0]  i_num,
    input  logic [rasq_pkg::DIV_D_BITS-1:0]  i_den,
    output logic                             o_busy,
    output logic [rasq_pkg::DIV_Q_BITS-1:0]  o_quot
);

    localparam int DW = rasq_pkg::DIV_D_BITS;
    localparam int QW = rasq_pkg::DIV_Q_BITS;
    localparam int CW = $clog2(QW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_q;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // one restoring step: shift in next dividend bit, try subtract
    assign w_trial = {r_rem, r_q[QW-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and quotient; upper dividend bits are already below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[rasq_pkg::DIV_N_BITS-1 -: DW];
            r_q   <= i_num[QW-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

>>> sv/rasq_ctrl.sv
module rasq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  rasq_pkg::t_status i_status,
    output rasq_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_RMUL   = 4'd2;
    localparam logic [3:0] S_DSTART = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_SCHK   = 4'd5;
    localparam logic [3:0] S_SMAG   = 4'd6;
    localparam logic [3:0] S_SSPD   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_status.tick_ramp) begin
                    n_state = S_RMUL;
                end else if (i_status.tick_settle) begin
                    n_state = S_SCHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = rasq_pkg::MUL_RAMP;
                n_state = i_status.ramp_done ? S_DONE : S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_DONE;
                end
            end
            S_SCHK: begin
                // offset product is taken early; it is used only on a lock
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = rasq_pkg::MUL_OFS;
                n_state = i_status.timeout ? S_DONE : S_SMAG;
            end
            S_SMAG: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = rasq_pkg::MUL_MAG;
                n_state = S_SSPD;
            end
            S_SSPD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = rasq_pkg::MUL_SPD;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/rasq_dp.sv
module rasq_dp #(
    parameter int ANGLE_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item fields
    input  logic [1:0]            i_op,
    input  logic [ANGLE_BITS-1:0] i_angle,
    input  logic [15:0]           i_dt,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [23:0]           i_cfg_wdata,
    // controller
    input  rasq_pkg::t_cmd        i_cmd,
    output rasq_pkg::t_status     o_status,
    // result
    input  logic                  i_m_tready,
    output logic                  o_valid,
    output logic [2:0]            o_phase_before,
    output logic [15:0]           o_drive_level_mv,
    output logic                  o_locked,
    output logic                  o_fault_code,
    output logic signed [19:0]    o_elec_offset
);

    localparam int AB    = ANGLE_BITS;
    localparam int OFS_W = ANGLE_BITS + 6;
    localparam int MW    = rasq_pkg::MUL_W;

    // configuration
    logic [23:0] r_ramp_len;
    logic [15:0] r_align_volt;
    logic [23:0] r_settle_tmo;
    logic [15:0] r_max_speed;
    logic [7:0]  r_samples;
    logic [5:0]  r_pole_pairs;
    logic        r_reverse;

    // sequencer state
    logic [2:0]    r_phase;
    logic          r_fault;
    logic [31:0]   r_elapsed;
    logic [7:0]    r_cnt;
    logic [AB-1:0] r_prev;
    logic [19:0]   r_offset;

    // item and work registers
    logic [1:0]       r_op;
    logic [AB-1:0]    r_angle;
    logic [15:0]      r_dt;
    logic [31:0]      r_sum;
    logic [AB-1:0]    r_mag;
    logic [39:0]      r_prod_a;
    logic [31:0]      r_prod_b;
    logic [OFS_W-1:0] r_ofs;

    // output register
    logic        r_ovalid;
    logic [2:0]  r_o_phase;
    logic [15:0] r_o_drive;
    logic        r_o_locked;
    logic        r_o_fault;
    logic [19:0] r_o_ofs;

    // next state at commit
    logic [2:0]    n_phase;
    logic          n_fault;
    logic [31:0]   n_elapsed;
    logic [7:0]    n_cnt;
    logic [AB-1:0] n_prev;
    logic [19:0]   n_offset;
    logic [15:0]   n_drive;

    logic [32:0]   w_sum;
    logic [AB:0]   w_diff;
    logic [MW-1:0] w_mul_a;
    logic [MW-1:0] w_mul_b;
    logic [2*MW-1:0] w_prod;
    logic          w_tick;
    logic          w_ramp_done;
    logic          w_timeout;
    logic          w_still;
    logic [7:0]    w_cnt_inc;
    logic          w_lock;
    logic [31:0]   w_ofs_ext;
    logic [19:0]   w_ofs_mag;
    logic [19:0]   w_ofs_val;
    logic          w_div_busy;
    logic [15:0]   w_quot;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_len   <= rasq_pkg::RST_RAMP_LEN;
            r_align_volt <= rasq_pkg::RST_ALIGN_VOLT;
            r_settle_tmo <= rasq_pkg::RST_SETTLE_TMO;
            r_max_speed  <= rasq_pkg::RST_MAX_SPEED;
            r_samples    <= rasq_pkg::RST_SAMPLES;
            r_pole_pairs <= rasq_pkg::RST_POLE_PAIRS;
            r_reverse    <= rasq_pkg::RST_REVERSE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rasq_pkg::CFG_RAMP_LEN:   r_ramp_len   <= i_cfg_wdata;
                rasq_pkg::CFG_ALIGN_VOLT: r_align_volt <= i_cfg_wdata[15:0];
                rasq_pkg::CFG_SETTLE_TMO: r_settle_tmo <= i_cfg_wdata;
                rasq_pkg::CFG_MAX_SPEED:  r_max_speed  <= i_cfg_wdata[15:0];
                rasq_pkg::CFG_SAMPLES:    r_samples    <= i_cfg_wdata[7:0];
                rasq_pkg::CFG_POLE_PAIRS: r_pole_pairs <= i_cfg_wdata[5:0];
                rasq_pkg::CFG_REVERSE:    r_reverse    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // saturating elapsed time and angle delta
    assign w_sum  = {1'b0, r_elapsed} + {17'd0, r_dt};
    assign w_diff = {1'b0, r_angle} - {1'b0, r_prev};

    // item capture and prep
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_angle <= i_angle;
            r_dt    <= i_dt;
        end
        if (i_cmd.prep) begin
            r_sum <= w_sum[32] ? rasq_pkg::ELAPSED_MAX : w_sum[31:0];
            r_mag <= w_diff[AB] ? AB'(-w_diff) : w_diff[AB-1:0];
        end
    end

    // shared multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            rasq_pkg::MUL_RAMP: begin
                w_mul_a = MW'(r_align_volt);
                w_mul_b = r_sum[MW-1:0];
            end
            rasq_pkg::MUL_MAG: begin
                w_mul_a = MW'(r_mag);
                w_mul_b = rasq_pkg::MAG_SCALE;
            end
            rasq_pkg::MUL_SPD: begin
                w_mul_a = MW'(r_max_speed);
                w_mul_b = MW'(r_dt);
            end
            rasq_pkg::MUL_OFS: begin
                w_mul_a = MW'(r_angle);
                w_mul_b = MW'(r_pole_pairs);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                rasq_pkg::MUL_RAMP: r_prod_a <= w_prod[39:0];
                rasq_pkg::MUL_MAG:  r_prod_a <= w_prod[39:0];
                rasq_pkg::MUL_SPD:  r_prod_b <= w_prod[31:0];
                rasq_pkg::MUL_OFS:  r_ofs    <= w_prod[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // drive level = align * elapsed / ramp length
    rasq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod_a),
        .i_den   (r_ramp_len),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // decisions
    assign w_tick      = (r_op == rasq_pkg::OP_TICK);
    assign w_ramp_done = (r_sum >= {8'd0, r_ramp_len});
    assign w_timeout   = (r_sum >= {8'd0, r_settle_tmo});
    assign w_still     = (r_prod_a < {8'd0, r_prod_b});
    assign w_cnt_inc   = (r_cnt == rasq_pkg::COUNT_MAX) ? r_cnt : r_cnt + 8'd1;
    assign w_lock      = w_still && (w_cnt_inc >= r_samples);

    // offset clamp and sign
    assign w_ofs_ext = 32'(r_ofs);
    assign w_ofs_mag = (w_ofs_ext > {12'd0, rasq_pkg::OFFSET_MAX}) ?
                       rasq_pkg::OFFSET_MAX : w_ofs_ext[19:0];
    assign w_ofs_val = r_reverse ? (20'd0 - w_ofs_mag) : w_ofs_mag;

    // state update for the item
    always_comb begin
        n_phase   = r_phase;
        n_fault   = r_fault;
        n_elapsed = r_elapsed;
        n_cnt     = r_cnt;
        n_prev    = r_prev;
        n_offset  = r_offset;
        n_drive   = '0;
        case (r_op)
            rasq_pkg::OP_START: begin
                n_phase   = rasq_pkg::PH_RAMP;
                n_fault   = rasq_pkg::FAULT_NONE;
                n_elapsed = '0;
                n_cnt     = '0;
                n_prev    = '0;
            end
            rasq_pkg::OP_ABORT: begin
                n_phase   = rasq_pkg::PH_IDLE;
                n_fault   = rasq_pkg::FAULT_NONE;
                n_elapsed = '0;
                n_cnt     = '0;
            end
            rasq_pkg::OP_TICK: begin
                if (r_phase == rasq_pkg::PH_RAMP) begin
                    if (w_ramp_done) begin
                        n_drive   = r_align_volt;
                        n_phase   = rasq_pkg::PH_SETTLE;
                        n_elapsed = '0;
                        n_cnt     = '0;
                        n_prev    = r_angle;
                    end else begin
                        n_drive   = w_quot;
                        n_elapsed = r_sum;
                    end
                end else if (r_phase == rasq_pkg::PH_SETTLE) begin
                    n_elapsed = r_sum;
                    if (w_timeout) begin
                        n_phase = rasq_pkg::PH_FAULT;
                        n_fault = rasq_pkg::FAULT_TIMEOUT;
                    end else begin
                        n_prev = r_angle;
                        n_cnt  = w_still ? w_cnt_inc : 8'd0;
                        if (w_lock) begin
                            n_offset = w_ofs_val;
                            n_phase  = rasq_pkg::PH_LOCKED;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rasq_pkg::PH_IDLE;
            r_fault   <= rasq_pkg::FAULT_NONE;
            r_elapsed <= '0;
            r_cnt     <= '0;
            r_prev    <= '0;
            r_offset  <= '0;
        end else if (i_cmd.commit) begin
            r_phase   <= n_phase;
            r_fault   <= n_fault;
            r_elapsed <= n_elapsed;
            r_cnt     <= n_cnt;
            r_prev    <= n_prev;
            r_offset  <= n_offset;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_phase  <= r_phase;
            r_o_drive  <= n_drive;
            r_o_locked <= (n_phase == rasq_pkg::PH_LOCKED);
            r_o_fault  <= n_fault;
            r_o_ofs    <= n_offset;
        end
    end

    assign o_status.tick_ramp   = w_tick && (r_phase == rasq_pkg::PH_RAMP);
    assign o_status.tick_settle = w_tick && (r_phase == rasq_pkg::PH_SETTLE);
    assign o_status.ramp_done   = w_ramp_done;
    assign o_status.timeout     = w_timeout;
    assign o_status.div_busy    = w_div_busy;
    assign o_status.out_free    = !r_ovalid || i_m_tready;

    assign o_valid          = r_ovalid && i_rst_n;
    assign o_phase_before   = r_o_phase;
    assign o_drive_level_mv = r_o_drive;
    assign o_locked         = r_o_locked;
    assign o_fault_code     = r_o_fault;
    assign o_elec_offset    = r_o_ofs;

endmodule

>>> sv/rotor_alignment_sequencer.sv
// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+--------------------------------------------
// s (item) | in  | i_s_tvalid/o_s_tready | i_s_tdata: operation, enc_angle, dt_us
// m (res)  | out | o_m_tvalid/i_m_tready | o_m_tdata: phase_before .. elec_offset
// cfg      | in  | i_cfg_we              | i_cfg_idx, i_cfg_wdata
//
// One item in flight: start, abort and ticks outside ramp/settle go from prep to commit; ramp end
// and settle timeout make one multiplier pass; other settle ticks make three passes through the
// 24x24 multiplier; ramp ticks that stay in ramp also run the 16-step restoring divider.
// Reset is synchronous, active low, and restores the register defaults.
// A result waits in the output register while the next item is taken; the
// sequencer stalls before its commit cycle only while that register is full.
module rotor_alignment_sequencer #(
    parameter int ANGLE_BITS = 14
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // [1:0] operation, [ANGLE_BITS+1:2] enc_angle, then dt_us (16), zero pad
    input  logic [((ANGLE_BITS + 25) / 8) * 8-1:0] i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // [2:0] phase_before, [18:3] drive_level_mv, [19] locked,
    // [20] fault_code, [40:21] elec_offset, [47:41] zero pad
    output logic [47:0]                           o_m_tdata,
    input  logic                                  i_cfg_we,
    input  logic [2:0]                            i_cfg_idx,
    input  logic [23:0]                           i_cfg_wdata
);

    rasq_pkg::t_cmd    w_cmd;
    rasq_pkg::t_status w_status;

    logic [2:0]         w_phase_before;
    logic [15:0]        w_drive;
    logic               w_locked;
    logic               w_fault;
    logic signed [19:0] w_offset;

    rasq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rasq_dp #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (i_s_tdata[1:0]),
        .i_angle          (i_s_tdata[2 +: ANGLE_BITS]),
        .i_dt             (i_s_tdata[2 + ANGLE_BITS +: 16]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_m_tready       (i_m_tready),
        .o_valid          (o_m_tvalid),
        .o_phase_before   (w_phase_before),
        .o_drive_level_mv (w_drive),
        .o_locked         (w_locked),
        .o_fault_code     (w_fault),
        .o_elec_offset    (w_offset)
    );

    // result packing, first field lowest
    assign o_m_tdata = {7'd0, w_offset, w_fault, w_locked, w_drive, w_phase_before};

endmodule

>>> sv/rasq_checker.sv
module rasq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or dropped while stalled");

    // one item at a time: no transfer in the cycle after an input transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready right after an input transfer");

    // locked and a timeout fault never show together
    a_lock_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[19] && o_m_tdata[20]))
        else $error("locked with fault reason set");

    // drive level only on items that entered in ramp
    a_drive_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] != rasq_pkg::PH_RAMP) |-> (o_m_tdata[18:3] == 16'd0))
        else $error("drive level outside ramp");

endmodule

bind rotor_alignment_sequencer rasq_checker u_rasq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
